FILE: design/rhcc_pkg.sv
// ============================================================================
// rhcc_pkg
// Shared types and constants of the RGB to HSV colour classifier.
// ============================================================================
package rhcc_pkg;

    // Result classes
    typedef enum logic [2:0] {
        CLS_NONE   = 3'd0,
        CLS_RED    = 3'd1,
        CLS_YELLOW = 3'd2,
        CLS_GREEN  = 3'd3,
        CLS_BLUE   = 3'd4,
        CLS_WHITE  = 3'd5,
        CLS_BLACK  = 3'd6
    } color_class_t;

    // Which channel supplies the hue formula
    typedef enum logic [1:0] {
        MAX_RED   = 2'd0,
        MAX_GREEN = 2'd1,
        MAX_BLUE  = 2'd2
    } max_sel_t;

    localparam int HUE_Q_BITS = 9;   // hue quotient bits, one per divider stage
    localparam int SAT_Q_BITS = 7;   // saturation quotient bits
    localparam int DIV_STAGES = HUE_Q_BITS;
    localparam int PRE_STAGES = 3;   // extrema, numerators, thresholds
    localparam int NUM_STAGES = PRE_STAGES + DIV_STAGES;

    // Payload carried through the divider stages
    typedef struct packed {
        logic [16:0]  hrem;
        logic [7:0]   hd;
        logic [8:0]   hq;
        logic [14:0]  srem;
        logic [7:0]   sd;
        logic [6:0]   sq;
        color_class_t cls;
        logic [6:0]   val;
    } div_t;

endpackage

FILE: design/rhcc_in_if.sv
// ============================================================================
// rhcc_in_if
// Sample channel: one RGB item with valid/ready handshake.
// ============================================================================
interface rhcc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;

    modport source (output valid, output red, output green, output blue, input ready);
    modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

FILE: design/rhcc_out_if.sv
// ============================================================================
// rhcc_out_if
// Result channel: class, hue, saturation and value with valid/ready.
// ============================================================================
interface rhcc_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] color_class;
    logic [8:0] hue_deg;
    logic [6:0] saturation_pct;
    logic [6:0] value_pct;

    modport source (output valid, output color_class, output hue_deg,
                    output saturation_pct, output value_pct, input ready);
    modport sink   (input valid, input color_class, input hue_deg,
                    input saturation_pct, input value_pct, output ready);
endinterface

FILE: design/rgb_hsv_color_classifier_core.sv
// ============================================================================
// rgb_hsv_color_classifier_core
// RGB sample to HSV conversion and colour classification, fully pipelined.
// ============================================================================
// Pipeline: from sample accept to result valid the item passes 12 register
//          stages (3 front stages plus one per hue quotient bit).
// Throughput: one item per cycle while the result is not stalled; the divider is unrolled into 9 stages.
// A stage holds its item while the stage after it is full and stalled; bubbles
// collapse, so a stalled result blocks the input only once every stage is full.
// Reset (rst_n, asynchronous, active low) empties the pipeline; no other state.
// ============================================================================
module rgb_hsv_color_classifier_core (
    input  logic      clk,
    input  logic      rst_n,
    rhcc_in_if.sink   sample,
    rhcc_out_if.source result
);

    localparam int NS = rhcc_pkg::NUM_STAGES;
    localparam int ND = rhcc_pkg::DIV_STAGES;
    localparam int NP = rhcc_pkg::PRE_STAGES;

    // ------------------------------------------------------------------
    // Handshake: per-stage load enable, ready chain from the output back
    // ------------------------------------------------------------------
    logic [NS-1:0] v_reg;
    logic [NS-1:0] en;

    always_comb
    begin
        en[NS-1] = ~v_reg[NS-1] | result.ready;
        for (int i = NS - 2; i >= 0; i--)
        begin
            en[i] = ~v_reg[i] | en[i+1];
        end
    end

    assign sample.ready = en[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                v_reg[0] <= sample.valid;
            end
            for (int i = 1; i < NS; i++)
            begin
                if (en[i])
                begin
                    v_reg[i] <= v_reg[i-1];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage A: extrema, spread and the channel difference for the hue
    // Ties: blue beats green beats red.
    // ------------------------------------------------------------------
    logic [7:0]         a_mx_next, a_mn_next;
    logic signed [8:0]  a_diff_next;
    rhcc_pkg::max_sel_t a_sel_next;

    logic [7:0]         a_mx_reg, a_d_reg;
    logic signed [8:0]  a_diff_reg;
    rhcc_pkg::max_sel_t a_sel_reg;

    always_comb
    begin
        a_mx_next = sample.red;
        a_mn_next = sample.red;
        if (sample.green > a_mx_next) a_mx_next = sample.green;
        if (sample.blue  > a_mx_next) a_mx_next = sample.blue;
        if (sample.green < a_mn_next) a_mn_next = sample.green;
        if (sample.blue  < a_mn_next) a_mn_next = sample.blue;

        if (a_mx_next == sample.blue)
        begin
            a_sel_next  = rhcc_pkg::MAX_BLUE;
            a_diff_next = $signed({1'b0, sample.red}) - $signed({1'b0, sample.green});
        end
        else if (a_mx_next == sample.green)
        begin
            a_sel_next  = rhcc_pkg::MAX_GREEN;
            a_diff_next = $signed({1'b0, sample.blue}) - $signed({1'b0, sample.red});
        end
        else
        begin
            a_sel_next  = rhcc_pkg::MAX_RED;
            a_diff_next = $signed({1'b0, sample.green}) - $signed({1'b0, sample.blue});
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            a_mx_reg   <= a_mx_next;
            a_d_reg    <= a_mx_next - a_mn_next;
            a_diff_reg <= a_diff_next;
            a_sel_reg  <= a_sel_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage B: hue numerator hn over hd, saturation numerator and divisor
    // Gray gives hn = 0 over hd = 1; zero maximum gives divisor 1.
    // ------------------------------------------------------------------
    logic [7:0]         b_base;
    logic [15:0]        b_bd;
    logic [16:0]        b_d360;
    logic signed [17:0] b_diff_ext;
    logic signed [17:0] b_hsum;
    logic signed [17:0] b_hwrap;

    logic [16:0] b_hn_reg;
    logic [7:0]  b_hd_reg;
    logic [14:0] b_sn_reg;
    logic [7:0]  b_sd_reg;
    logic [7:0]  b_mx_reg;
    logic [7:0]  b_d_reg;

    always_comb
    begin
        case (a_sel_reg)
            rhcc_pkg::MAX_BLUE:  b_base = 8'd240;
            rhcc_pkg::MAX_GREEN: b_base = 8'd120;
            default:             b_base = 8'd0;
        endcase
        b_bd       = 16'(b_base) * 16'(a_d_reg);
        b_d360     = 17'(a_d_reg) * 17'd360;
        b_diff_ext = 18'(a_diff_reg);
        b_hsum     = b_diff_ext * 18'sd60 + $signed({2'b00, b_bd});
        if (b_hsum < 0)
        begin
            b_hwrap = b_hsum + $signed({1'b0, b_d360});
        end
        else
        begin
            b_hwrap = b_hsum;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            b_hn_reg <= b_hwrap[16:0];
            b_hd_reg <= (a_d_reg == 8'd0) ? 8'd1 : a_d_reg;
            b_sn_reg <= 15'(a_d_reg) * 15'd100;
            b_sd_reg <= (a_mx_reg == 8'd0) ? 8'd1 : a_mx_reg;
            b_mx_reg <= a_mx_reg;
            b_d_reg  <= a_d_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage C: exact threshold tests by cross-multiplication, class pick,
    // value percent (divide by 255 as (x + (x >> 8) + 1) >> 8, exact here)
    // ------------------------------------------------------------------
    logic [16:0] c_hd20, c_hd80, c_hd140, c_hd200, c_hd260, c_hd320;
    logic        c_sat_hi, c_sat_lo, c_val_hi, c_val_lo;
    logic        c_win_red, c_win_yel, c_win_grn, c_win_blu;
    logic [14:0] c_vx;
    logic [14:0] c_vsum;
    rhcc_pkg::color_class_t c_cls;
    rhcc_pkg::div_t         c_next;

    always_comb
    begin
        c_hd20  = 17'(b_hd_reg) * 17'd20;
        c_hd80  = 17'(b_hd_reg) * 17'd80;
        c_hd140 = 17'(b_hd_reg) * 17'd140;
        c_hd200 = 17'(b_hd_reg) * 17'd200;
        c_hd260 = 17'(b_hd_reg) * 17'd260;
        c_hd320 = 17'(b_hd_reg) * 17'd320;

        c_win_red = (b_hn_reg < c_hd20) || (b_hn_reg > c_hd320);
        c_win_yel = (b_hn_reg > c_hd20)  && (b_hn_reg < c_hd80);
        c_win_grn = (b_hn_reg > c_hd80)  && (b_hn_reg < c_hd140);
        c_win_blu = (b_hn_reg > c_hd200) && (b_hn_reg < c_hd260);

        // 100d >= 50M  <=>  2d >= M ; 100d < 10M  <=>  10d < M
        c_sat_hi = (b_mx_reg != 8'd0) && ({1'b0, b_d_reg, 1'b0} >= 10'(b_mx_reg));
        c_sat_lo = (b_mx_reg == 8'd0) || ((12'(b_d_reg) * 12'd10) < 12'(b_mx_reg));
        // 100M > 22950 <=> M >= 230 ; 100M < 5100 <=> M <= 50
        c_val_hi = (b_mx_reg >= 8'd230);
        c_val_lo = (b_mx_reg <= 8'd50);

        if (c_win_red && c_sat_hi)      c_cls = rhcc_pkg::CLS_RED;
        else if (c_win_yel && c_sat_hi) c_cls = rhcc_pkg::CLS_YELLOW;
        else if (c_win_grn && c_sat_hi) c_cls = rhcc_pkg::CLS_GREEN;
        else if (c_win_blu && c_sat_hi) c_cls = rhcc_pkg::CLS_BLUE;
        else if (c_sat_lo && c_val_hi)  c_cls = rhcc_pkg::CLS_WHITE;
        else if (c_val_lo)              c_cls = rhcc_pkg::CLS_BLACK;
        else                            c_cls = rhcc_pkg::CLS_NONE;

        c_vx   = 15'(b_mx_reg) * 15'd100;
        c_vsum = c_vx + (c_vx >> 8) + 15'd1;

        c_next.hrem = b_hn_reg;
        c_next.hd   = b_hd_reg;
        c_next.hq   = '0;
        c_next.srem = b_sn_reg;
        c_next.sd   = b_sd_reg;
        c_next.sq   = '0;
        c_next.cls  = c_cls;
        c_next.val  = c_vsum[14:8];
    end

    rhcc_pkg::div_t c_reg;

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            c_reg <= c_next;
        end
    end

    // ------------------------------------------------------------------
    // Divider stages: restoring division, one quotient bit per stage, MSB
    // first. Hue takes all nine bits; saturation joins for its low seven.
    // ------------------------------------------------------------------
    rhcc_pkg::div_t div_reg  [ND];
    rhcc_pkg::div_t div_next [ND];

    always_comb
    begin
        rhcc_pkg::div_t src;
        logic [16:0]    hsh;
        logic [14:0]    ssh;
        for (int k = 0; k < ND; k++)
        begin
            src = (k == 0) ? c_reg : div_reg[k-1];
            div_next[k] = src;
            hsh = 17'(src.hd) << (ND - 1 - k);
            if (src.hrem >= hsh)
            begin
                div_next[k].hrem = src.hrem - hsh;
                div_next[k].hq[ND-1-k] = 1'b1;
            end
            if ((ND - 1 - k) < rhcc_pkg::SAT_Q_BITS)
            begin
                ssh = 15'(src.sd) << (ND - 1 - k);
                if (src.srem >= ssh)
                begin
                    div_next[k].srem = src.srem - ssh;
                    div_next[k].sq[ND-1-k] = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < ND; k++)
        begin
            if (en[NP+k])
            begin
                div_reg[k] <= div_next[k];
            end
        end
    end

    // ------------------------------------------------------------------
    // Output: last divider stage is the result register
    // ------------------------------------------------------------------
    assign result.valid          = v_reg[NS-1];
    assign result.color_class    = div_reg[ND-1].cls;
    assign result.hue_deg        = div_reg[ND-1].hq;
    assign result.saturation_pct = div_reg[ND-1].sq;
    assign result.value_pct      = div_reg[ND-1].val;

endmodule
